### hw/rtl/fedl_pkg.sv
// Shared constants, types and codes for the feedback echo delay line.
package fedl_pkg;

  localparam int DELAY_DEPTH = 131072;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);

  localparam int SAMPLE_W    = 16;
  localparam int PCT_W       = 7;
  localparam int ECHO_W      = SAMPLE_W + 1;
  localparam int PROD_W      = ECHO_W + PCT_W + 1;
  localparam int MAG_W       = 24;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
  localparam int QUOT_W      = 17;

  localparam int OQ_DEPTH    = 8;
  localparam int OQ_AW       = $clog2(OQ_DEPTH);
  localparam int OQ_CW       = OQ_AW + 1;

  localparam int RATE_W          = 17;
  localparam int MS_W            = 11;
  localparam int CH_W            = 2;
  localparam int DLY_PROD_W      = RATE_W + MS_W;
  localparam int DLY_RECIP_W     = 29;
  localparam int DLY_RECIP_SHIFT = 38;
  localparam logic [DLY_RECIP_W-1:0] DLY_RECIP = 29'd274877907;
  localparam int DLY_MUL_W       = DLY_PROD_W + DLY_RECIP_W;
  localparam int DLY_QUOT_W      = 19;
  localparam int DLY_SCALED_W    = DLY_QUOT_W + CH_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RATE_W;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_MS    = 3'd0,
    REG_SAMPLE_RATE = 3'd1,
    REG_CHANNELS    = 3'd2,
    REG_ECHO_VOLUME = 3'd3,
    REG_FEEDBACK    = 3'd4,
    REG_SURROUND    = 3'd5,
    REG_PATH_ENABLE = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PATH_CAPTURE  = 2'd0,
    PATH_PLAYBACK = 2'd1,
    PATH_SERIES   = 2'd2
  } path_code_t;

  typedef enum logic [1:0] {
    DLY_IDLE,
    DLY_MUL,
    DLY_DIV,
    DLY_SCALE
  } dly_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                cap_en;
    logic                play_en;
    logic                slot;
  } item_t;

  typedef struct packed {
    logic  valid;
    logic  en;
    addr_t wa;
    addr_t ra;
    addr_t nba;
    logic  ok_a;
    logic  ok_b;
  } path_req_t;

  typedef struct packed {
    logic [PCT_W-1:0] vol;
    logic [PCT_W-1:0] fbp;
    logic             sur;
  } path_cfg_t;

  typedef struct packed {
    logic  valid;
    logic  cap_en;
    logic  play_en;
    addr_t cap_w;
    addr_t play_w;
  } hist_t;

endpackage

### hw/rtl/fedl_delay.sv
// Delay unit: rate * ms / 1000, times channels, clamped to the last line address.
module fedl_delay import fedl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RATE_W-1:0] rate,
  input  logic [MS_W-1:0]   ms,
  input  logic [CH_W-1:0]   ch,
  output logic              busy,
  output addr_t             delay
);

  dly_state_t                state, state_next;
  logic [DLY_PROD_W-1:0]     dq, dq_next;
  logic [DLY_QUOT_W-1:0]     quot, quot_next;
  addr_t                     delay_next;
  logic [DLY_PROD_W-1:0]     prod;
  logic [DLY_MUL_W-1:0]      recip_prod;
  logic [DLY_SCALED_W-1:0]   scaled;

  assign prod       = DLY_PROD_W'(rate) * DLY_PROD_W'(ms);
  assign recip_prod = DLY_MUL_W'(dq) * DLY_MUL_W'(DLY_RECIP);
  assign scaled = (ch[0] ? DLY_SCALED_W'(quot) : '0)
                + (ch[1] ? (DLY_SCALED_W'(quot) << 1) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DLY_MUL;
    end else begin
      state <= state_next;
    end
    dq    <= dq_next;
    quot  <= quot_next;
    delay <= delay_next;
  end

  always_comb begin
    state_next = state;
    dq_next    = dq;
    quot_next  = quot;
    delay_next = delay;
    unique case (state)
      DLY_IDLE: begin
      end
      DLY_MUL: begin
        dq_next    = prod;
        state_next = DLY_DIV;
      end
      DLY_DIV: begin
        quot_next  = recip_prod[DLY_RECIP_SHIFT +: DLY_QUOT_W];
        state_next = DLY_SCALE;
      end
      DLY_SCALE: begin
        delay_next = (scaled > DLY_SCALED_W'(DELAY_DEPTH - 1)) ? addr_t'(DELAY_DEPTH - 1)
                                                               : scaled[ADDR_W-1:0];
        state_next = DLY_IDLE;
      end
      default: begin
        state_next = DLY_IDLE;
      end
    endcase
    if (start) begin
      state_next = DLY_MUL;
    end
  end

  assign busy = (state != DLY_IDLE);

endmodule

### hw/rtl/fedl_front.sv
// Input side: accept items and classify them into per-path enables.
module fedl_front import fedl_pkg::*; (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SAMPLE_W-1:0] s_axis_tdata,  // [15:0] sample_in
  input  logic [2:0]          s_axis_tuser,  // [1:0] path, [2] channel_slot
  input  logic [1:0]          path_en,
  input  logic                hold,
  input  logic                q_full,
  output logic                push,
  output item_t               item
);

  logic cap_sel, play_sel;

  always_comb begin
    unique case (s_axis_tuser[1:0])
      PATH_CAPTURE: begin
        cap_sel  = 1'b1;
        play_sel = 1'b0;
      end
      PATH_PLAYBACK: begin
        cap_sel  = 1'b0;
        play_sel = 1'b1;
      end
      PATH_SERIES: begin
        cap_sel  = 1'b1;
        play_sel = 1'b1;
      end
      default: begin
        cap_sel  = 1'b1;
        play_sel = 1'b1;
      end
    endcase
  end

  assign s_axis_tready = !q_full && !hold;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item.sample   = s_axis_tdata;
  assign item.cap_en   = cap_sel && path_en[0];
  assign item.play_en  = play_sel && path_en[1];
  assign item.slot     = s_axis_tuser[2];

endmodule

### hw/rtl/fedl_queue.sv
// Two-entry item queue between the front and the back.
module fedl_queue import fedl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  input  logic  pop,
  output logic  valid,
  output logic  full,
  output item_t dout
);

  item_t      ent [2];
  logic       wp, rp;
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= din;
    end
  end

  assign dout  = ent[rp];
  assign valid = (cnt != 2'd0);
  assign full  = (cnt == 2'd2);

endmodule

### hw/rtl/fedl_path.sv
// One delay path: delay line memory, echo scaling and saturating write-back.
module fedl_path import fedl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  path_req_t           req,
  input  logic [SAMPLE_W-1:0] sample,
  input  path_cfg_t           cfg,
  output logic                out_valid,
  output logic [SAMPLE_W-1:0] out_sample
);

  function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W+2:0] v);
    logic [SAMPLE_W-1:0] r;
    if (v > 19'sd32767) begin
      r = 16'h7fff;
    end else if (v < -19'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  logic [SAMPLE_W-1:0] dline [DELAY_DEPTH];
  logic [SAMPLE_W-1:0] rd_a, rd_b;

  logic                p1_valid, p1_en, p1_ok_a, p1_ok_b;
  logic [SAMPLE_W-1:0] p1_sample;
  addr_t               p1_wa;

  logic                p2_valid, p2_en;
  logic [SAMPLE_W-1:0] p2_sample;
  addr_t               p2_wa;
  logic signed [PROD_W-1:0] p2_prod_v, p2_prod_f;

  logic                p3_valid, p3_en, p3_neg_v, p3_neg_f;
  logic [SAMPLE_W-1:0] p3_sample;
  addr_t               p3_wa;
  logic [QUOT_W-1:0]   p3_q_v, p3_q_f;

  logic signed [SAMPLE_W-1:0] echo_a, echo_b;
  logic signed [ECHO_W-1:0]   echo;
  logic signed [PROD_W-1:0]   prod_v, prod_f;
  logic [PROD_W-1:0]          abs_v, abs_f;
  logic [MAG_W+RECIP_W-1:0]   rp_v, rp_f;
  logic [QUOT_W-1:0]          q_f_eff;
  logic signed [QUOT_W:0]     sv_v, sv_f;
  logic signed [SAMPLE_W+2:0] sum_v, sum_f;
  logic [SAMPLE_W-1:0]        fb_val;
  logic                       wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dline[p3_wa] <= fb_val;
    end
    rd_a <= dline[req.ra];
    rd_b <= dline[req.nba];
  end

  assign echo_a = p1_ok_a ? $signed(rd_a) : '0;
  assign echo_b = (cfg.sur && p1_ok_b) ? $signed(rd_b) : '0;
  assign echo   = {echo_a[SAMPLE_W-1], echo_a} - {echo_b[SAMPLE_W-1], echo_b};
  assign prod_v = echo * $signed({1'b0, cfg.vol});
  assign prod_f = echo * $signed({1'b0, cfg.fbp});

  assign abs_v = p2_prod_v[PROD_W-1] ? PROD_W'(-p2_prod_v) : PROD_W'(p2_prod_v);
  assign abs_f = p2_prod_f[PROD_W-1] ? PROD_W'(-p2_prod_f) : PROD_W'(p2_prod_f);
  assign rp_v  = abs_v[MAG_W-1:0] * RECIP_100;
  assign rp_f  = abs_f[MAG_W-1:0] * RECIP_100;

  assign q_f_eff = cfg.sur ? (p3_q_f >> 1) : p3_q_f;
  assign sv_v    = p3_neg_v ? -$signed({1'b0, p3_q_v}) : $signed({1'b0, p3_q_v});
  assign sv_f    = p3_neg_f ? -$signed({1'b0, q_f_eff}) : $signed({1'b0, q_f_eff});
  assign sum_v   = $signed({{3{p3_sample[SAMPLE_W-1]}}, p3_sample})
                 + $signed({sv_v[QUOT_W], sv_v});
  assign sum_f   = $signed({{3{p3_sample[SAMPLE_W-1]}}, p3_sample})
                 + $signed({sv_f[QUOT_W], sv_f});
  assign fb_val  = sat16(sum_f);
  assign wr_en   = p3_valid && p3_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_valid  <= req.valid;
      p2_valid  <= p1_valid;
      p3_valid  <= p2_valid;
      out_valid <= p3_valid;
    end
    p1_en     <= req.en;
    p1_ok_a   <= req.ok_a;
    p1_ok_b   <= req.ok_b;
    p1_sample <= sample;
    p1_wa     <= req.wa;

    p2_en     <= p1_en;
    p2_sample <= p1_sample;
    p2_wa     <= p1_wa;
    p2_prod_v <= prod_v;
    p2_prod_f <= prod_f;

    p3_en     <= p2_en;
    p3_sample <= p2_sample;
    p3_wa     <= p2_wa;
    p3_neg_v  <= p2_prod_v[PROD_W-1];
    p3_neg_f  <= p2_prod_f[PROD_W-1];
    p3_q_v    <= rp_v[RECIP_SHIFT +: QUOT_W];
    p3_q_f    <= rp_f[RECIP_SHIFT +: QUOT_W];

    out_sample <= p3_en ? sat16(sum_v) : p3_sample;
  end

  a_no_read_of_pending_write: assert property (@(posedge clk) disable iff (rst)
    (wr_en && req.valid && req.en) |->
      ((req.ra != p3_wa) && (!cfg.sur || (req.nba != p3_wa))))
    else $error("delay line read collides with write-back in flight");

endmodule

### hw/rtl/fedl_back.sv
// Back end: issue with hazard check, capture and playback paths, result queue.
module fedl_back import fedl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  addr_t               delay,
  input  path_cfg_t           cfg,
  input  logic                q_valid,
  input  item_t               q_item,
  output logic                q_pop,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [SAMPLE_W-1:0] m_axis_tdata   // [15:0] sample_out
);

  function automatic addr_t addr_inc(input addr_t a);
    return (a == addr_t'(DELAY_DEPTH - 1)) ? '0 : a + addr_t'(1);
  endfunction

  function automatic addr_t addr_dec(input addr_t a);
    return (a == '0) ? addr_t'(DELAY_DEPTH - 1) : a - addr_t'(1);
  endfunction

  function automatic addr_t addr_sub(input addr_t a, input addr_t d);
    return (a >= d) ? a - d : a - d + addr_t'(DELAY_DEPTH);
  endfunction

  addr_t      wc, wp;
  logic       fullc, fullp;
  hist_t      hist [3];
  path_req_t  pdly [4];
  logic [OQ_CW-1:0] credit;

  addr_t      rc, nbc, rp, nbp;
  logic       hazard, issue;
  path_req_t  cap_req, play_req_new, play_req;

  logic                cap_valid, play_valid;
  logic [SAMPLE_W-1:0] cap_sample, play_sample;

  logic [SAMPLE_W-1:0] oq [OQ_DEPTH];
  logic [OQ_AW-1:0]    oq_wp, oq_rp;
  logic [OQ_CW-1:0]    oq_cnt;
  logic                oq_pop;

  assign rc  = addr_sub(wc, delay);
  assign nbc = q_item.slot ? addr_dec(rc) : addr_inc(rc);
  assign rp  = addr_sub(wp, delay);
  assign nbp = q_item.slot ? addr_dec(rp) : addr_inc(rp);

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (hist[i].valid) begin
        if (q_item.cap_en && hist[i].cap_en &&
            ((rc == hist[i].cap_w) || (cfg.sur && (nbc == hist[i].cap_w)))) begin
          hazard = 1'b1;
        end
        if (q_item.play_en && hist[i].play_en &&
            ((rp == hist[i].play_w) || (cfg.sur && (nbp == hist[i].play_w)))) begin
          hazard = 1'b1;
        end
      end
    end
  end

  assign issue = q_valid && !hist[0].valid && (credit < OQ_CW'(OQ_DEPTH)) && !hazard;
  assign q_pop = issue;

  assign cap_req.valid = issue;
  assign cap_req.en    = q_item.cap_en;
  assign cap_req.wa    = wc;
  assign cap_req.ra    = rc;
  assign cap_req.nba   = nbc;
  assign cap_req.ok_a  = fullc || (rc < wc);
  assign cap_req.ok_b  = fullc || (nbc < wc);

  assign play_req_new.valid = issue;
  assign play_req_new.en    = q_item.play_en;
  assign play_req_new.wa    = wp;
  assign play_req_new.ra    = rp;
  assign play_req_new.nba   = nbp;
  assign play_req_new.ok_a  = fullp || (rp < wp);
  assign play_req_new.ok_b  = fullp || (nbp < wp);

  always_ff @(posedge clk) begin
    if (rst) begin
      wc     <= '0;
      wp     <= '0;
      fullc  <= 1'b0;
      fullp  <= 1'b0;
      credit <= '0;
      for (int i = 0; i < 3; i++) begin
        hist[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        pdly[i] <= '0;
      end
    end else begin
      if (issue && q_item.cap_en) begin
        wc <= addr_inc(wc);
        if (wc == addr_t'(DELAY_DEPTH - 1)) begin
          fullc <= 1'b1;
        end
      end
      if (issue && q_item.play_en) begin
        wp <= addr_inc(wp);
        if (wp == addr_t'(DELAY_DEPTH - 1)) begin
          fullp <= 1'b1;
        end
      end
      credit <= credit + OQ_CW'(issue) - OQ_CW'(oq_pop);
      hist[0] <= '{valid: issue, cap_en: q_item.cap_en, play_en: q_item.play_en,
                   cap_w: wc, play_w: wp};
      hist[1] <= hist[0];
      hist[2] <= hist[1];
      pdly[0] <= play_req_new;
      for (int i = 1; i < 4; i++) begin
        pdly[i] <= pdly[i-1];
      end
    end
  end

  assign play_req = pdly[3];

  fedl_path u_cap (
    .clk        (clk),
    .rst        (rst),
    .req        (cap_req),
    .sample     (q_item.sample),
    .cfg        (cfg),
    .out_valid  (cap_valid),
    .out_sample (cap_sample)
  );

  fedl_path u_play (
    .clk        (clk),
    .rst        (rst),
    .req        (play_req),
    .sample     (cap_sample),
    .cfg        (cfg),
    .out_valid  (play_valid),
    .out_sample (play_sample)
  );

  assign oq_pop        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (oq_cnt != '0);
  assign m_axis_tdata  = oq[oq_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp  <= '0;
      oq_rp  <= '0;
      oq_cnt <= '0;
    end else begin
      if (play_valid) begin
        oq_wp <= (oq_wp == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_wp + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rp <= (oq_rp == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_rp + OQ_AW'(1);
      end
      oq_cnt <= oq_cnt + OQ_CW'(play_valid) - OQ_CW'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (play_valid) begin
      oq[oq_wp] <= play_sample;
    end
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= OQ_CW'(OQ_DEPTH))
    else $error("issue credit exceeds result queue depth");

  a_result_room: assert property (@(posedge clk) disable iff (rst)
    play_valid |-> (oq_cnt < OQ_CW'(OQ_DEPTH)))
    else $error("result arrives with no room in result queue");

  a_path_align: assert property (@(posedge clk) disable iff (rst)
    cap_valid == play_req.valid)
    else $error("capture output and playback request out of step");

endmodule

### hw/rtl/feedback_echo_delay_line.sv
// Top level of the feedback echo delay line: config registers, front, queue, back.
// Items pass the item queue, the capture path and the playback path into the result queue.
// Issue waits while the last issue is still in hist[0], and while a delay line read hits
// a write-back still in flight in the same path (delays of 0 to 2 samples).
// Reset and each config write start a delay computation; s_axis_tready is low meanwhile.
module feedback_echo_delay_line import fedl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,  // [15:0] sample_in
  input  logic [2:0]            s_axis_tuser,  // [1:0] path, [2] channel_slot
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [SAMPLE_W-1:0]   m_axis_tdata,  // [15:0] sample_out
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MS_W-1:0]   delay_ms;
  logic [RATE_W-1:0] sample_rate;
  logic [CH_W-1:0]   channel_count;
  logic [PCT_W-1:0]  echo_volume_pct;
  logic [PCT_W-1:0]  feedback_pct;
  logic              surround_enable;
  logic [1:0]        path_enable;

  path_cfg_t cfg;
  logic      dly_busy;
  addr_t     delay;
  logic      push, q_full, q_valid, q_pop;
  item_t     in_item, q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms        <= '0;
      sample_rate     <= RATE_W'(44100);
      channel_count   <= CH_W'(2);
      echo_volume_pct <= PCT_W'(50);
      feedback_pct    <= PCT_W'(50);
      surround_enable <= 1'b0;
      path_enable     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DELAY_MS:    delay_ms        <= cfg_data[MS_W-1:0];
        REG_SAMPLE_RATE: sample_rate     <= cfg_data[RATE_W-1:0];
        REG_CHANNELS:    channel_count   <= cfg_data[CH_W-1:0];
        REG_ECHO_VOLUME: echo_volume_pct <= cfg_data[PCT_W-1:0];
        REG_FEEDBACK:    feedback_pct    <= cfg_data[PCT_W-1:0];
        REG_SURROUND:    surround_enable <= cfg_data[0];
        REG_PATH_ENABLE: path_enable     <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.vol = echo_volume_pct;
  assign cfg.fbp = feedback_pct;
  assign cfg.sur = surround_enable && (channel_count == CH_W'(2));

  fedl_delay u_delay (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_we),
    .rate  (sample_rate),
    .ms    (delay_ms),
    .ch    (channel_count),
    .busy  (dly_busy),
    .delay (delay)
  );

  fedl_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .path_en       (path_enable),
    .hold          (dly_busy || cfg_we),
    .q_full        (q_full),
    .push          (push),
    .item          (in_item)
  );

  fedl_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (in_item),
    .pop   (q_pop),
    .valid (q_valid),
    .full  (q_full),
    .dout  (q_item)
  );

  fedl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .delay         (delay),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### bench/tb_top.sv
// Self-checking testbench for the feedback echo delay line: predictor, scoreboard, stimulus.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fedl_pkg::*;

  localparam int          WATCHDOG_LIMIT  = 400000;
  localparam int          SETTLE_CYCLES   = 16;
  localparam int          RANDOM_PHASES   = 10;
  localparam int          PHASE_ITEMS     = 140;
  localparam logic [1:0]  PATH_SERIES_ALT = 2'd3;
  localparam logic [1:0]  PEN_CAPTURE     = 2'b01;
  localparam logic [1:0]  PEN_PLAYBACK    = 2'b10;
  localparam int          LINE_CAP        = 0;
  localparam int          LINE_PLAY       = 1;

  class echo_scoreboard;
    shortint         line_mem[2][DELAY_DEPTH];
    int unsigned     wr_pos[2];
    logic [10:0]     delay_ms;
    logic [16:0]     rate;
    logic [1:0]      chans;
    logic [6:0]      vol_pct;
    logic [6:0]      fb_pct;
    logic            surround;
    logic [1:0]      path_en;
    logic [15:0]     expected_q[$];
    int              errors;
    int              matched;
    int              echo_hits;

    function new();
      wr_pos[LINE_CAP]  = 0;
      wr_pos[LINE_PLAY] = 0;
      delay_ms  = 11'd0;
      rate      = 17'd44100;
      chans     = 2'd2;
      vol_pct   = 7'd50;
      fb_pct    = 7'd50;
      surround  = 1'b0;
      path_en   = 2'd0;
      errors    = 0;
      matched   = 0;
      echo_hits = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DELAY_MS:    delay_ms = val[10:0];
        REG_SAMPLE_RATE: rate     = val[16:0];
        REG_CHANNELS:    chans    = val[1:0];
        REG_ECHO_VOLUME: vol_pct  = val[6:0];
        REG_FEEDBACK:    fb_pct   = val[6:0];
        REG_SURROUND:    surround = val[0];
        REG_PATH_ENABLE: path_en  = val[1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_sample(longint v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
    endfunction

    function longint echo_pass(int which, longint smp, logic slot);
      longint      dly;
      longint      echo;
      longint      out_v;
      longint      fb_v;
      int unsigned w;
      int unsigned r;
      int unsigned nb;
      bit          sur_on;
      sur_on = surround && (chans == 2'd2);
      dly = (longint'(rate) * longint'(delay_ms) / 1000) * longint'(chans);
      if (dly > DELAY_DEPTH - 1) dly = DELAY_DEPTH - 1;
      w = wr_pos[which];
      r = int'((longint'(w) + DELAY_DEPTH - dly) % DELAY_DEPTH);
      echo = line_mem[which][r];
      if (sur_on) begin
        if (slot) nb = (r + DELAY_DEPTH - 1) % DELAY_DEPTH;
        else nb = (r + 1) % DELAY_DEPTH;
        echo = echo - longint'(line_mem[which][nb]);
      end
      out_v = clamp_sample(smp + echo * longint'(vol_pct) / 100);
      fb_v  = clamp_sample(smp + echo * longint'(fb_pct) / (sur_on ? 200 : 100));
      line_mem[which][w] = shortint'(fb_v);
      wr_pos[which] = (w + 1) % DELAY_DEPTH;
      return out_v;
    endfunction

    function void note_input(logic [15:0] smp, logic [1:0] pth, logic slot);
      longint s;
      s = longint'($signed(smp));
      if (pth != PATH_PLAYBACK && path_en[0]) s = echo_pass(LINE_CAP, s, slot);
      if (pth != PATH_CAPTURE && path_en[1]) s = echo_pass(LINE_PLAY, s, slot);
      if (s != longint'($signed(smp))) echo_hits++;
      expected_q.push_back(s[15:0]);
    endfunction

    function void check_output(logic [15:0] got);
      logic [15:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item on output, got %0d", $time, $signed(got));
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                 $time, $signed(want), $signed(got));
        errors++;
      end
      else begin
        matched++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata;   // [15:0] sample_in
  logic [2:0]            s_axis_tuser;   // [1:0] path, [2] channel_slot
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [SAMPLE_W-1:0]   m_axis_tdata;   // [15:0] sample_out
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  echo_scoreboard sb;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             idle_run;
  int             settings_count;
  int             items_sent;

  feedback_echo_delay_line DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_input(s_axis_tdata, s_axis_tuser[1:0], s_axis_tuser[2]);
      end
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || cfg_we) begin
        idle_run = 0;
      end
      else begin
        idle_run++;
      end
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d items outstanding",
                 $time, idle_run, sb.expected_q.size());
        $display("feedback_echo_delay_line verification failed");
        $finish;
      end
    end
  end

  task send_item(input logic [15:0] smp, input logic [1:0] pth, input logic slot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= {slot, pth};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    items_sent++;
    @(negedge clk);
  endtask

  task drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task write_settings(input logic [10:0] ms, input logic [16:0] sr, input logic [1:0] ch,
                      input logic [6:0] vol, input logic [6:0] fbp, input logic sur,
                      input logic [1:0] pen);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_DELAY_MS, CFG_DATA_W'(ms));
    write_reg(REG_SAMPLE_RATE, CFG_DATA_W'(sr));
    write_reg(REG_CHANNELS, CFG_DATA_W'(ch));
    write_reg(REG_ECHO_VOLUME, CFG_DATA_W'(vol));
    write_reg(REG_FEEDBACK, CFG_DATA_W'(fbp));
    write_reg(REG_SURROUND, CFG_DATA_W'(sur));
    write_reg(REG_PATH_ENABLE, CFG_DATA_W'(pen));
    cfg_we <= 1'b0;
    settings_count++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [16:0] sr;
    logic [10:0] ms;
    int          ms_cap;
    int          pause_at;
    logic        slot;

    clk            = 1'b0;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_DELAY_MS;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    idle_run       = 0;
    settings_count = 0;
    items_sent     = 0;
    sb = new();

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: both paths off, every path code passes through
    send_item(16'h7FFF, PATH_CAPTURE, 1'b0);
    send_item(16'h8000, PATH_PLAYBACK, 1'b1);
    send_item(16'h0000, PATH_SERIES, 1'b0);
    send_item(16'hFFFF, PATH_SERIES_ALT, 1'b1);

    // surround, zero delay at the start of the line: neighbor wraps to the top end
    write_settings(11'd0, 17'd1000, 2'd2, 7'd110, 7'd110, 1'b1, PEN_CAPTURE);
    send_item(16'h7FFF, PATH_CAPTURE, 1'b1);

    // two-sample delay: capture read sits at the top end, neighbor wraps to entry zero
    write_settings(11'd1, 17'd1000, 2'd2, 7'd110, 7'd110, 1'b1, PEN_CAPTURE | PEN_PLAYBACK);
    send_item(16'h8000, PATH_SERIES, 1'b0);
    send_item(16'h8000, PATH_SERIES, 1'b1);
    send_item(16'h7FFF, PATH_PLAYBACK, 1'b0);
    send_item(16'h7FFF, PATH_CAPTURE, 1'b1);
    send_item(16'h1234, PATH_SERIES_ALT, 1'b0);
    send_item(16'hEDCB, PATH_SERIES, 1'b1);

    // out-of-range registers at full width: delay saturates to the last line address
    write_settings(11'd2047, 17'h1FFFF, 2'd3, 7'd127, 7'd127, 1'b1, PEN_CAPTURE | PEN_PLAYBACK);
    send_item(16'h7FFF, PATH_SERIES, 1'b0);
    send_item(16'h8000, PATH_CAPTURE, 1'b1);
    send_item(16'h5555, PATH_PLAYBACK, 1'b0);

    // one-sample delay, mono: surround requested but inactive, back-to-back hazards
    write_settings(11'd1, 17'd1000, 2'd1, 7'd100, 7'd100, 1'b1, PEN_CAPTURE | PEN_PLAYBACK);
    send_item(16'h4000, PATH_SERIES, 1'b0);
    send_item(16'h4000, PATH_SERIES, 1'b1);
    send_item(16'hC000, PATH_SERIES, 1'b0);
    send_item(16'h7FFF, PATH_CAPTURE, 1'b1);
    send_item(16'h8000, PATH_PLAYBACK, 1'b0);
    send_item(16'hAAAA, PATH_SERIES_ALT, 1'b1);

    // zero channels gives zero delay; no echo gain, no feedback
    write_settings(11'd1024, 17'd96000, 2'd0, 7'd0, 7'd0, 1'b0, PEN_CAPTURE | PEN_PLAYBACK);
    send_item(16'h0001, PATH_SERIES, 1'b0);
    send_item(16'hFFFE, PATH_SERIES, 1'b1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(3))
        0: sr = 17'd44100;
        1: sr = 17'd48000;
        2: sr = 17'd8000;
        default: sr = 17'($urandom_range(96000, 1));
      endcase
      if (ph % 5 == 4) begin
        ms = 11'($urandom_range(2047));
        if (ph == 9) sr = 17'($urandom_range(17'h1FFFF, 1));
      end
      else begin
        ms_cap = 80000 / int'(sr);
        if (ms_cap > 2047) ms_cap = 2047;
        ms = 11'($urandom_range(ms_cap));
      end
      write_settings(ms, sr,
                     ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(2, 1)),
                     ($urandom_range(7) == 0) ? 7'd127 : 7'($urandom_range(110)),
                     ($urandom_range(7) == 0) ? 7'd127 : 7'($urandom_range(110)),
                     1'($urandom),
                     ($urandom_range(3) == 0) ? 2'($urandom) : 2'b11);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      pause_at = $urandom_range(PHASE_ITEMS - 1, 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == pause_at) drain_results();
        slot = ($urandom_range(9) == 0) ? 1'($urandom) : 1'(i);
        send_item(pick_sample(), 2'($urandom), slot);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d samples through %0d register settings; %0d results checked.",
             items_sent, settings_count, sb.matched);
    $display("Echo changed %0d outputs; extremes, wraps, zero and long delays included.",
             sb.echo_hits);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("feedback_echo_delay_line verification clean");
    end
    else begin
      $display("feedback_echo_delay_line verification failed");
    end
    $finish;
  end

endmodule
